// File: rtl/lpog_pkg.sv
`timescale 1ns / 1ps

package lpog_pkg;

  localparam int OP_W       = 2;
  localparam int POINT_W    = 15;
  localparam int RANGE_W    = 14;
  localparam int INDEX_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int HALF_W     = 6;
  localparam int CPM_W      = 16;
  localparam int TRIG_W     = 16;

  localparam logic [HALF_W-1:0]  RST_HALF_SIZE = 6'd63;
  localparam logic [CPM_W-1:0]   RST_CPM       = 16'd2560;
  localparam logic [TRIG_W-1:0]  RST_COS       = 16'd16384;
  localparam logic [TRIG_W-1:0]  RST_SIN       = 16'd0;
  localparam logic [RANGE_W-1:0] RST_MIN_RANGE = 14'd205;
  localparam logic [RANGE_W-1:0] RST_MAX_RANGE = 14'd8602;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MARKED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_SIZE = 3'd0,
    REG_CPM       = 3'd1,
    REG_COS       = 3'd2,
    REG_SIN       = 3'd3,
    REG_MIN_RANGE = 3'd4,
    REG_MAX_RANGE = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROT,
    S_SUM,
    S_SCALE,
    S_CELL,
    S_READ,
    S_RDONE
  } state_t;

endpackage

// File: rtl/lidar_point_occupancy_grid_core.sv
`timescale 1ns / 1ps

// Occupancy grid rasterizer for lidar returns, centered on the robot.
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
// operation (clear grid, plot one point, read one cell). Every input item gives
// exactly one result item on m_tvalid/m_tready/m_tdata/m_tuser, in order.
// Registers are written on the cfg channel, which is always ready; write them
// only while no item is in flight.
// One item is processed at a time. A plot item passes through the rotation
// multipliers, sum, scale multiplier, cell index and write, and the output
// register; when its range is rejected, its result is made after the rotation
// step. A read item uses a registered grid memory read, and a clear item
// sweeps the grid memory one entry per cycle over all 2**(2*IW) entries
// (16384 at the default size). The grid memory has one write port, and the
// sweep and the point writes share it.
// The result is held in an output register, so a new item is accepted while a
// finished result still waits; when the receiver stalls and a second result
// is ready, the block waits until the first one is taken.
// After reset the same sweep clears all 2**(2*IW) grid entries (16384 at the
// default size), with s_tready low; registers return to their reset values.
module lidar_point_occupancy_grid_core #(
  parameter int MAX_HALF_SIZE = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // point_x, point_y, point_range, read_row, read_col
  input  logic [lpog_pkg::S_TDATA_W-1:0]    s_tdata,
  // operation
  input  logic [lpog_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // occupied, cell_row, cell_col
  output logic [lpog_pkg::M_TDATA_W-1:0]    m_tdata,
  // status
  output logic [lpog_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpog_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpog_pkg::*;

  localparam int IW    = $clog2(2 * MAX_HALF_SIZE + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int CMPW  = (IW + 1 > INDEX_W) ? IW + 1 : INDEX_W;

  logic [HALF_W-1:0]  half_size;
  logic [CPM_W-1:0]   cells_per_meter;
  logic signed [TRIG_W-1:0] heading_cos;
  logic signed [TRIG_W-1:0] heading_sin;
  logic [RANGE_W-1:0] min_range;
  logic [RANGE_W-1:0] max_range;

  state_t state, state_next;

  logic signed [POINT_W-1:0] px, py;
  logic range_ok;
  logic [INDEX_W-1:0] rd_row, rd_col;

  logic signed [POINT_W+TRIG_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [31:0] rx, ry;
  logic signed [47:0] tx, ty;
  logic signed [48:0] tx_prod, ty_prod;

  logic [IW-1:0]   h;
  logic [IW:0]     two_h;
  logic [15:0]     hi_x, hi_y, cx, cy;
  logic            outside;
  logic            rd_inb;

  logic            grid [DEPTH];
  logic            mem_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [AW-1:0]   rd_addr;

  logic [AW-1:0]   clr_addr, clr_addr_next;
  logic            clr_report, clr_report_next;

  status_t         res_status, res_status_next;
  logic            res_occ, res_occ_next;
  logic [INDEX_W-1:0] res_row, res_row_next, res_col, res_col_next;
  logic            res_pend, res_pend_next;
  logic            load_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !res_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size       <= RST_HALF_SIZE;
      cells_per_meter <= RST_CPM;
      heading_cos     <= RST_COS;
      heading_sin     <= RST_SIN;
      min_range       <= RST_MIN_RANGE;
      max_range       <= RST_MAX_RANGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_HALF_SIZE: half_size       <= cfg_data[HALF_W-1:0];
        REG_CPM:       cells_per_meter <= cfg_data[CPM_W-1:0];
        REG_COS:       heading_cos     <= cfg_data[TRIG_W-1:0];
        REG_SIN:       heading_sin     <= cfg_data[TRIG_W-1:0];
        REG_MIN_RANGE: min_range       <= cfg_data[RANGE_W-1:0];
        REG_MAX_RANGE: max_range       <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(half_size) > 32'(MAX_HALF_SIZE)) begin
      h = IW'(MAX_HALF_SIZE);
    end else begin
      h = IW'(half_size);
    end
  end
  assign two_h = {h, 1'b0};

  assign tx_prod = rx * $signed({1'b0, cells_per_meter});
  assign ty_prod = ry * $signed({1'b0, cells_per_meter});

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      px       <= s_tdata[POINT_W-1:0];
      py       <= s_tdata[2*POINT_W-1:POINT_W];
      range_ok <= (s_tdata[2*POINT_W+RANGE_W-1:2*POINT_W] >= min_range) &&
                  (s_tdata[2*POINT_W+RANGE_W-1:2*POINT_W] <= max_range);
      rd_row   <= s_tdata[2*POINT_W+RANGE_W+INDEX_W-1:2*POINT_W+RANGE_W];
      rd_col   <= s_tdata[2*POINT_W+RANGE_W+2*INDEX_W-1:2*POINT_W+RANGE_W+INDEX_W];
    end
    p_xc <= px * heading_cos;
    p_ys <= py * heading_sin;
    p_xs <= px * heading_sin;
    p_yc <= py * heading_cos;
    rx   <= 32'(p_xc) - 32'(p_ys);
    ry   <= 32'(p_xs) + 32'(p_yc);
    tx   <= tx_prod[47:0];
    ty   <= ty_prod[47:0];
  end

  // Adding the offset touches only the upper word; a negative sum with a
  // nonzero fraction moves up by one so that truncation goes toward zero.
  assign hi_x = tx[47:32] + 16'(h);
  assign hi_y = ty[47:32] + 16'(h);
  assign cx   = hi_x + 16'(hi_x[15] && (tx[31:0] != 32'd0));
  assign cy   = hi_y + 16'(hi_y[15] && (ty[31:0] != 32'd0));
  assign outside = cx[15] || cy[15] || (cx > 16'(two_h)) || (cy > 16'(two_h));

  assign rd_inb  = (CMPW'(rd_row) <= CMPW'(two_h)) && (CMPW'(rd_col) <= CMPW'(two_h));
  assign rd_addr = {IW'(rd_row), IW'(rd_col)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_waddr] <= mem_wdata;
    end
    mem_q <= grid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      res_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_report <= clr_report_next;
      res_pend   <= res_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_occ    <= res_occ_next;
    res_row    <= res_row_next;
    res_col    <= res_col_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    clr_report_next = clr_report;
    res_status_next = res_status;
    res_occ_next    = res_occ;
    res_row_next    = res_row;
    res_col_next    = res_col;
    res_pend_next   = res_pend;
    mem_we          = 1'b0;
    mem_waddr       = clr_addr;
    mem_wdata       = 1'b0;
    load_out        = 1'b0;

    if (res_pend && (!m_tvalid || m_tready)) begin
      load_out      = 1'b1;
      res_pend_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == {AW{1'b1}}) begin
          clr_report_next = 1'b0;
          state_next      = S_IDLE;
          if (clr_report) begin
            res_status_next = ST_DONE;
            res_occ_next    = 1'b0;
            res_row_next    = '0;
            res_col_next    = '0;
            res_pend_next   = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          case (op_t'(s_tuser))
            OP_CLEAR: begin
              clr_addr_next   = '0;
              clr_report_next = 1'b1;
              state_next      = S_CLEAR;
            end
            OP_PLOT: state_next = S_ROT;
            OP_READ: state_next = S_READ;
            default: begin
              res_status_next = ST_DONE;
              res_occ_next    = 1'b0;
              res_row_next    = '0;
              res_col_next    = '0;
              res_pend_next   = 1'b1;
            end
          endcase
        end
      end
      S_ROT: begin
        if (range_ok) begin
          state_next = S_SUM;
        end else begin
          res_status_next = ST_REJECTED;
          res_occ_next    = 1'b0;
          res_row_next    = '0;
          res_col_next    = '0;
          res_pend_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SUM:   state_next = S_SCALE;
      S_SCALE: state_next = S_CELL;
      S_CELL: begin
        res_pend_next = 1'b1;
        state_next    = S_IDLE;
        if (outside) begin
          res_status_next = ST_OUTSIDE;
          res_occ_next    = 1'b0;
          res_row_next    = '0;
          res_col_next    = '0;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = {cy[IW-1:0], cx[IW-1:0]};
          mem_wdata       = 1'b1;
          res_status_next = ST_MARKED;
          res_occ_next    = 1'b1;
          res_row_next    = INDEX_W'(cy[IW-1:0]);
          res_col_next    = INDEX_W'(cx[IW-1:0]);
        end
      end
      S_READ: state_next = S_RDONE;
      S_RDONE: begin
        res_status_next = ST_DONE;
        res_occ_next    = rd_inb && mem_q;
        res_row_next    = rd_row;
        res_col_next    = rd_col;
        res_pend_next   = 1'b1;
        state_next      = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_col, res_row, res_occ};
    end
  end

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("item accepted during grid sweep");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_CELL))
    else $error("grid written outside sweep or plot");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

  a_marked_occupied: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status == ST_MARKED) |-> res_occ)
    else $error("marked cell reported as empty");

endmodule
